@@ rtl/bfl_pkg.sv @@
// Shared constants for the byte FIFO with line count.
// No dependencies; used by byte_fifo_with_line_count_unit and bfl_checker.
package bfl_pkg;

  localparam int DEPTH_DEF = 64;
  localparam int CNT_W     = 7;
  localparam int BYTE_W    = 8;
  localparam int FUNC_W    = 3;

  localparam logic [BYTE_W-1:0] NEWLINE = 8'h0A;

  localparam logic [FUNC_W-1:0] FUNC_WRITE   = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_READ    = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_PEEK    = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR   = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_GETLINE = 3'd4;

endpackage

@@ rtl/bfl_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
module bfl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ rtl/byte_fifo_with_line_count_unit.sv @@
// Byte FIFO with newline count: write, read n, peek n, clear, get line.
// Write, clear and errors: one result the cycle after accept; busy stays low.
// Peek n: emit pass only; each byte goes through the registered RAM read and output, one per cycle.
// Read n / get line of n bytes: a counting pass over the single RAM read port
// precedes the emit pass, and busy stays high through both passes.
// Reset (async, active low) empties the FIFO and sets capacity to DEPTH.
module byte_fifo_with_line_count_unit #(
  parameter int DEPTH = bfl_pkg::DEPTH_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [bfl_pkg::FUNC_W-1:0]  func_i,
  input  logic [bfl_pkg::BYTE_W-1:0]  in_byte_i,
  input  logic [bfl_pkg::CNT_W-1:0]   size_i,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [bfl_pkg::CNT_W-1:0]   cfg_capacity_i,
  output logic                        out_strobe_o,
  output logic                        status_o,
  output logic [bfl_pkg::BYTE_W-1:0]  out_byte_o,
  output logic                        last_o,
  output logic [bfl_pkg::CNT_W-1:0]   fill_count_o,
  output logic [bfl_pkg::CNT_W-1:0]   line_count_o
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = bfl_pkg::CNT_W;
  localparam logic [CW-1:0] CAP_MAX = CW'(DEPTH);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]    state_q, state_d;
  logic [AW-1:0] wr_pos_q, wr_pos_d;
  logic [AW-1:0] rd_pos_q, rd_pos_d;
  logic [AW-1:0] scan_pos_q, scan_pos_d;
  logic [AW-1:0] emit_pos_q, emit_pos_d;
  logic [CW-1:0] held_q, held_d;
  logic [CW-1:0] lines_q, lines_d;
  logic [CW-1:0] cap_q, cap_d;
  logic [CW-1:0] tot_q, tot_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] nl_q, nl_d;
  logic [CW-1:0] iss_q, iss_d;
  logic          pend_q, pend_d;
  logic          get_q, get_d;

  logic                       strobe_q, strobe_d;
  logic                       status_q, status_d;
  logic [bfl_pkg::BYTE_W-1:0] byte_q, byte_d;
  logic                       last_q, last_d;
  logic [CW-1:0]              fill_q, fill_d;
  logic [CW-1:0]              lcnt_q, lcnt_d;

  logic                       ram_we;
  logic [AW-1:0]              ram_raddr;
  logic [bfl_pkg::BYTE_W-1:0] ram_rdata;

  logic          accept;
  logic          cfg_wr;
  logic [CW-1:0] cnt_inc;
  logic [CW-1:0] nl_inc;
  logic          scan_done;

  function automatic logic [AW-1:0] adv(input logic [AW-1:0] pos, input logic [CW-1:0] cap);
    logic [CW-1:0] nxt;
    nxt = CW'(pos) + CW'(1);
    return (nxt >= cap) ? '0 : nxt[AW-1:0];
  endfunction

  assign busy        = (state_q != ST_IDLE);
  // hold off a capacity write while a command is offered
  assign cfg_ready_o = !busy && !start;
  assign accept      = start && !busy;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;

  assign cnt_inc = cnt_q + CW'(1);
  assign nl_inc  = nl_q + CW'(ram_rdata == bfl_pkg::NEWLINE);

  bfl_ram #(
    .WIDTH (bfl_pkg::BYTE_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wr_pos_q),
    .wdata_i (in_byte_i),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d    = state_q;
    wr_pos_d   = wr_pos_q;
    rd_pos_d   = rd_pos_q;
    scan_pos_d = scan_pos_q;
    emit_pos_d = emit_pos_q;
    held_d     = held_q;
    lines_d    = lines_q;
    cap_d      = cap_q;
    tot_d      = tot_q;
    cnt_d      = cnt_q;
    nl_d       = nl_q;
    iss_d      = iss_q;
    pend_d     = pend_q;
    get_d      = get_q;
    strobe_d   = 1'b0;
    status_d   = 1'b0;
    byte_d     = '0;
    last_d     = 1'b1;
    ram_we     = 1'b0;
    ram_raddr  = (state_q == ST_SCAN) ? scan_pos_q : emit_pos_q;
    scan_done  = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (cfg_wr) begin
          // clamp capacity into 1..DEPTH and empty the buffer
          if (cfg_capacity_i == '0) begin
            cap_d = CW'(1);
          end else if (cfg_capacity_i > CAP_MAX) begin
            cap_d = CAP_MAX;
          end else begin
            cap_d = cfg_capacity_i;
          end
          wr_pos_d = '0;
          rd_pos_d = '0;
          held_d   = '0;
          lines_d  = '0;
        end else if (accept) begin
          strobe_d   = 1'b1;
          scan_pos_d = rd_pos_q;
          emit_pos_d = rd_pos_q;
          cnt_d      = '0;
          nl_d       = '0;
          iss_d      = '0;
          pend_d     = 1'b0;
          unique case (func_i) inside
            bfl_pkg::FUNC_WRITE: begin
              if (held_q >= cap_q) begin
                status_d = 1'b1;
              end else begin
                ram_we   = 1'b1;
                wr_pos_d = adv(wr_pos_q, cap_q);
                held_d   = held_q + CW'(1);
                lines_d  = lines_q + CW'(in_byte_i == bfl_pkg::NEWLINE);
              end
            end
            bfl_pkg::FUNC_READ, bfl_pkg::FUNC_PEEK: begin
              if (size_i == '0 || size_i > held_q) begin
                status_d = 1'b1;
              end else begin
                // burst: results come from the emit pass
                strobe_d = 1'b0;
                tot_d    = size_i;
                get_d    = 1'b0;
                state_d  = (func_i == bfl_pkg::FUNC_PEEK) ? ST_EMIT : ST_SCAN;
              end
            end
            bfl_pkg::FUNC_CLEAR: begin
              wr_pos_d = '0;
              rd_pos_d = '0;
              held_d   = '0;
              lines_d  = '0;
            end
            bfl_pkg::FUNC_GETLINE: begin
              if (lines_q == '0 || held_q == '0) begin
                status_d = 1'b1;
              end else begin
                strobe_d = 1'b0;
                get_d    = 1'b1;
                state_d  = ST_SCAN;
              end
            end
            default: begin
              status_d = 1'b1;
            end
          endcase
        end
      end

      ST_SCAN: begin
        // count bytes and newlines to consume so every result shows final counts
        scan_pos_d = adv(scan_pos_q, cap_q);
        pend_d     = 1'b1;
        if (pend_q) begin
          cnt_d     = cnt_inc;
          nl_d      = nl_inc;
          scan_done = get_q ? (ram_rdata == bfl_pkg::NEWLINE) : (cnt_inc == tot_q);
          if (scan_done) begin
            state_d  = ST_EMIT;
            tot_d    = cnt_inc;
            held_d   = held_q - cnt_inc;
            lines_d  = lines_q - nl_inc;
            rd_pos_d = scan_pos_q;
            cnt_d    = '0;
            iss_d    = '0;
            pend_d   = 1'b0;
          end
        end
      end

      ST_EMIT: begin
        if (iss_q != tot_q) begin
          iss_d      = iss_q + CW'(1);
          emit_pos_d = adv(emit_pos_q, cap_q);
          pend_d     = 1'b1;
        end else begin
          pend_d = 1'b0;
        end
        if (pend_q) begin
          strobe_d = 1'b1;
          byte_d   = ram_rdata;
          last_d   = (cnt_inc == tot_q);
          cnt_d    = cnt_inc;
          if (cnt_inc == tot_q) begin
            state_d = ST_IDLE;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    fill_d = held_d;
    lcnt_d = lines_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      wr_pos_q <= '0;
      rd_pos_q <= '0;
      held_q   <= '0;
      lines_q  <= '0;
      cap_q    <= CAP_MAX;
      pend_q   <= 1'b0;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      wr_pos_q <= wr_pos_d;
      rd_pos_q <= rd_pos_d;
      held_q   <= held_d;
      lines_q  <= lines_d;
      cap_q    <= cap_d;
      pend_q   <= pend_d;
      strobe_q <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    scan_pos_q <= scan_pos_d;
    emit_pos_q <= emit_pos_d;
    tot_q      <= tot_d;
    cnt_q      <= cnt_d;
    nl_q       <= nl_d;
    iss_q      <= iss_d;
    get_q      <= get_d;
    status_q   <= status_d;
    byte_q     <= byte_d;
    last_q     <= last_d;
    fill_q     <= fill_d;
    lcnt_q     <= lcnt_d;
  end

  assign out_strobe_o = strobe_q;
  assign status_o     = status_q;
  assign out_byte_o   = byte_q;
  assign last_o       = last_q;
  assign fill_count_o = fill_q;
  assign line_count_o = lcnt_q;

endmodule

@@ rtl/bfl_checker.sv @@
// Port-level checks for byte_fifo_with_line_count_unit, bound to the top level.
// Depends on bfl_pkg for field widths.
module bfl_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       start,
  input logic                       busy,
  input logic                       cfg_ready_o,
  input logic                       out_strobe_o,
  input logic                       status_o,
  input logic [bfl_pkg::BYTE_W-1:0] out_byte_o,
  input logic                       last_o,
  input logic [bfl_pkg::CNT_W-1:0]  fill_count_o,
  input logic [bfl_pkg::CNT_W-1:0]  line_count_o
);

  // every accepted transaction shows a result or holds busy in the next cycle
  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (out_strobe_o || busy))
    else $error("accepted transaction made no progress");

  // a burst delivers its bytes in consecutive cycles
  a_burst_gapless: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_strobe_o && !last_o) |=> out_strobe_o)
    else $error("gap inside a burst");

  a_error_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_strobe_o && status_o) |-> (last_o && out_byte_o == '0))
    else $error("error result is not a single empty transaction");

  a_lines_le_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_strobe_o |-> (line_count_o <= fill_count_o))
    else $error("more newlines than held bytes");

  a_cfg_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o |-> !busy)
    else $error("configuration ready while busy");

endmodule

bind byte_fifo_with_line_count_unit bfl_checker u_bfl_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start        (start),
  .busy         (busy),
  .cfg_ready_o  (cfg_ready_o),
  .out_strobe_o (out_strobe_o),
  .status_o     (status_o),
  .out_byte_o   (out_byte_o),
  .last_o       (last_o),
  .fill_count_o (fill_count_o),
  .line_count_o (line_count_o)
);
